### hw/rtl/sdg_pkg.sv
// ----------------------------------------------------------------------------
// sdg_pkg
// Shared types, codes and helpers for the spatial dilemma grid block.
// ----------------------------------------------------------------------------
package sdg_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int GRID_RESET  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int PAYOFF_W    = 5;
  localparam int SCORE_W     = 8;
  localparam int STEP_W      = 4;

  localparam logic [PAYOFF_W-1:0] PAYOFF_MAX        = 5'd28;
  localparam logic [PAYOFF_W-1:0] REWARD_RESET      = 5'd10;
  localparam logic [PAYOFF_W-1:0] TEMPTATION_RESET  = 5'd19;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REWARD      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPTATION  = 2'd3;

  // request opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_GEN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // sweep phases
  localparam logic [1:0] PH_SCORE  = 2'd0;
  localparam logic [1:0] PH_CHOOSE = 2'd1;
  localparam logic [1:0] PH_COMMIT = 2'd2;

  // step zero is the cell itself, steps one to eight the neighbours
  localparam logic [STEP_W-1:0] STEP_LAST_NB  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SWEEP_END = 4'd9;
  localparam logic [STEP_W-1:0] STEP_COMMIT_END = 4'd1;

  typedef struct packed {
    logic              sweep;
    logic [1:0]        phase;
    logic [STEP_W-1:0] step;
    logic              pos_clr;
    logic              pos_adv;
    logic              in_take;
    logic              load_read;
    logic              load_gen;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic out_free;
    logic out_full;
  } dp_stat_t;

  function automatic logic signed [1:0] nb_dc(input logic [STEP_W-1:0] step);
    logic signed [1:0] d;
    case (step)
      4'd3, 4'd4, 4'd5: d = 2'sd1;
      4'd6, 4'd7, 4'd8: d = -2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dr(input logic [STEP_W-1:0] step);
    logic signed [1:0] d;
    case (step)
      4'd1, 4'd4, 4'd7: d = 2'sd1;
      4'd2, 4'd5, 4'd8: d = -2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

### hw/rtl/sdg_req_if.sv
// ----------------------------------------------------------------------------
// sdg_req_if
// Request channel: opcode, cell position and strategy to write.
// ----------------------------------------------------------------------------
interface sdg_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] row;
  logic [5:0] column;
  logic       strategy_in;

  modport source (output valid, opcode, row, column, strategy_in, input ready);
  modport sink (input valid, opcode, row, column, strategy_in, output ready);
endinterface

### hw/rtl/sdg_rsp_if.sv
// ----------------------------------------------------------------------------
// sdg_rsp_if
// Result channel: read answers and generation completions.
// ----------------------------------------------------------------------------
interface sdg_rsp_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic strategy_out;
  logic previous_strategy;

  modport source (output valid, result_kind, strategy_out, previous_strategy, input ready);
  modport sink (input valid, result_kind, strategy_out, previous_strategy, output ready);
endinterface

### hw/rtl/sdg_ram.sv
// ----------------------------------------------------------------------------
// sdg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdg_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/sdg_ctrl.sv
// ----------------------------------------------------------------------------
// sdg_ctrl
// Sequencer: request decode, three cell sweeps per generation, result loads.
// ----------------------------------------------------------------------------
module sdg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic [1:0]       opcode_i,
  output logic             req_ready_o,
  input  sdg_pkg::dp_stat_t stat_i,
  output sdg_pkg::dp_cmd_t  cmd_o
);
  import sdg_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SCORE  = 3'd2;
  localparam logic [2:0] ST_CHOOSE = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o   = stat_i.out_free;
        cmd_o.in_take = req_valid_i && stat_i.out_free;
        if (cmd_o.in_take) begin
          case (opcode_i)
            OP_READ: state_d = ST_READ;
            OP_GEN: begin
              state_d       = ST_SCORE;
              step_d        = '0;
              cmd_o.pos_clr = 1'b1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.load_read = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_SCORE, ST_CHOOSE, ST_COMMIT: begin
        cmd_o.sweep = 1'b1;
        cmd_o.step  = step_q;
        case (state_q)
          ST_SCORE:  cmd_o.phase = PH_SCORE;
          ST_CHOOSE: cmd_o.phase = PH_CHOOSE;
          default:   cmd_o.phase = PH_COMMIT;
        endcase
        if ((state_q == ST_COMMIT) ? (step_q == STEP_COMMIT_END)
                                   : (step_q == STEP_SWEEP_END)) begin
          step_d = '0;
          if (stat_i.pos_last) begin
            cmd_o.pos_clr = 1'b1;
            case (state_q)
              ST_SCORE:  state_d = ST_CHOOSE;
              ST_CHOOSE: state_d = ST_COMMIT;
              default:   state_d = ST_DONE;
            endcase
          end else begin
            cmd_o.pos_adv = 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        cmd_o.load_gen = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

### hw/rtl/sdg_datapath.sv
// ----------------------------------------------------------------------------
// sdg_datapath
// Configuration, cell stores, neighbour addressing, score and choice logic.
// ----------------------------------------------------------------------------
module sdg_datapath #(
  parameter int MaxSide = sdg_pkg::MAX_SIDE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sdg_pkg::dp_cmd_t               cmd_i,
  output sdg_pkg::dp_stat_t              stat_o,
  input  logic                           cfg_we_i,
  input  logic [sdg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]                     opcode_i,
  input  logic [5:0]                     row_i,
  input  logic [5:0]                     column_i,
  input  logic                           strategy_in_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output logic                           result_kind_o,
  output logic                           strategy_out_o,
  output logic                           previous_strategy_o
);
  import sdg_pkg::*;

  localparam int Depth = MaxSide * MaxSide;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(MaxSide);
  localparam int SW    = $clog2(MaxSide + 1);
  localparam int PW    = CW + 2;
  localparam int SideRst = (GRID_RESET > MaxSide) ? MaxSide : GRID_RESET;

  // configuration
  logic [SW-1:0]       width_q, height_q;
  logic [PAYOFF_W-1:0] reward_q, tempt_q;
  logic [SW-1:0]       side_clamp;
  logic [PAYOFF_W-1:0] pay_clamp;

  always_comb begin
    if (int'(cfg_data_i) < 2) begin
      side_clamp = SW'(2);
    end else if (int'(cfg_data_i) > MaxSide) begin
      side_clamp = SW'(MaxSide);
    end else begin
      side_clamp = SW'(cfg_data_i);
    end
    pay_clamp = (cfg_data_i[PAYOFF_W-1:0] > PAYOFF_MAX) ? PAYOFF_MAX
                                                        : cfg_data_i[PAYOFF_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SW'(SideRst);
      height_q <= SW'(SideRst);
      reward_q <= REWARD_RESET;
      tempt_q  <= TEMPTATION_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  width_q  <= side_clamp;
        CFG_GRID_HEIGHT: height_q <= side_clamp;
        CFG_REWARD:      reward_q <= pay_clamp;
        CFG_TEMPTATION:  tempt_q  <= pay_clamp;
        default: ;
      endcase
    end
  end

  function automatic logic [SCORE_W-1:0] pair_pay(input logic me, input logic other,
                                                  input logic [PAYOFF_W-1:0] rew,
                                                  input logic [PAYOFF_W-1:0] tmp);
    logic [SCORE_W-1:0] p;
    if (other) begin
      p = '0;
    end else begin
      p = SCORE_W'(me ? tmp : rew);
    end
    return p;
  endfunction

  // sweep position
  logic [CW-1:0] row_q, col_q;
  logic          col_last, row_last;

  assign col_last = int'(col_q) == int'(width_q) - 1;
  assign row_last = int'(row_q) == int'(height_q) - 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.pos_clr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.pos_adv) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // neighbour address
  logic signed [PW-1:0] nr, nc;
  logic                 nb_ok;
  logic [AW-1:0]        self_addr, nb_addr, in_addr;
  logic                 in_inside;

  assign nr = $signed({2'b00, row_q}) + PW'(nb_dr(cmd_i.step));
  assign nc = $signed({2'b00, col_q}) + PW'(nb_dc(cmd_i.step));
  assign nb_ok = (nr >= 0) && (nc >= 0)
              && (nr < $signed({{(PW-SW){1'b0}}, height_q}))
              && (nc < $signed({{(PW-SW){1'b0}}, width_q}));
  assign self_addr = AW'(int'(row_q) * MaxSide + int'(col_q));
  assign nb_addr   = AW'(int'(nr[CW-1:0]) * MaxSide + int'(nc[CW-1:0]));
  assign in_inside = (int'(row_i) < int'(height_q)) && (int'(column_i) < int'(width_q));
  assign in_addr   = AW'(int'(row_i) * MaxSide + int'(column_i));

  // read stage
  logic                sweep_d1;
  logic [1:0]          phase_d1;
  logic [STEP_W-1:0]   step_d1;
  logic                nb_ok_d1;
  logic                strat_rd, prev_rd, pend_rd;
  logic [SCORE_W-1:0]  score_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_d1 <= 1'b0;
    end else begin
      sweep_d1 <= cmd_i.sweep;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_d1 <= cmd_i.phase;
    step_d1  <= cmd_i.step;
    nb_ok_d1 <= nb_ok;
  end

  // accumulate and choose
  logic               me_q, me_d;
  logic [SCORE_W-1:0] sum_q, sum_d;
  logic [SCORE_W-1:0] own_q, own_d;
  logic               found_q, found_d;
  logic [SCORE_W-1:0] best_q, best_d;
  logic               bs_q, bs_d;
  logic               consume, last_nb;
  logic               score_we, pend_we, commit_we, write_we;
  logic               pend_wdata;

  assign consume = sweep_d1 && (step_d1 <= STEP_LAST_NB);
  assign last_nb = consume && (step_d1 == STEP_LAST_NB);

  always_comb begin
    me_d    = me_q;
    sum_d   = sum_q;
    own_d   = own_q;
    found_d = found_q;
    best_d  = best_q;
    bs_d    = bs_q;
    if (consume) begin
      if (step_d1 == '0) begin
        me_d    = strat_rd;
        sum_d   = pair_pay(strat_rd, strat_rd, reward_q, tempt_q);
        own_d   = score_rd;
        found_d = 1'b0;
      end else if (nb_ok_d1) begin
        sum_d = sum_q + pair_pay(me_q, strat_rd, reward_q, tempt_q);
        if (!found_q || score_rd > best_q) begin
          found_d = 1'b1;
          best_d  = score_rd;
          bs_d    = strat_rd;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    me_q    <= me_d;
    sum_q   <= sum_d;
    own_q   <= own_d;
    best_q  <= best_d;
    bs_q    <= bs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  assign score_we   = last_nb && (phase_d1 == PH_SCORE);
  assign pend_we    = last_nb && (phase_d1 == PH_CHOOSE);
  assign pend_wdata = (found_d && best_d > own_q) ? bs_d : me_q;
  assign commit_we  = consume && (phase_d1 == PH_COMMIT) && (step_d1 == '0);
  assign write_we   = cmd_i.in_take && (opcode_i == OP_WRITE) && in_inside;

  // stores
  logic [AW-1:0] strat_waddr, strat_raddr;
  logic          strat_wdata, prev_wdata;

  assign strat_waddr = commit_we ? self_addr : in_addr;
  assign strat_wdata = commit_we ? pend_rd : strategy_in_i;
  assign prev_wdata  = commit_we ? strat_rd : strategy_in_i;
  assign strat_raddr = cmd_i.sweep ? nb_addr : in_addr;

  sdg_ram #(.Width(1), .Depth(Depth)) u_strat_ram (
    .clk_i   (clk_i),
    .we_i    (commit_we || write_we),
    .waddr_i (strat_waddr),
    .wdata_i (strat_wdata),
    .raddr_i (strat_raddr),
    .rdata_o (strat_rd)
  );

  sdg_ram #(.Width(1), .Depth(Depth)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (commit_we || write_we),
    .waddr_i (strat_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (in_addr),
    .rdata_o (prev_rd)
  );

  sdg_ram #(.Width(SCORE_W), .Depth(Depth)) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (score_we),
    .waddr_i (self_addr),
    .wdata_i (sum_d),
    .raddr_i (nb_addr),
    .rdata_o (score_rd)
  );

  sdg_ram #(.Width(1), .Depth(Depth)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (self_addr),
    .wdata_i (pend_wdata),
    .raddr_i (self_addr),
    .rdata_o (pend_rd)
  );

  // result register
  logic inside_q;
  logic out_valid_q;
  logic kind_q, sout_q, pout_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      inside_q <= in_inside;
    end
    if (cmd_i.load_read) begin
      kind_q <= 1'b0;
      sout_q <= inside_q & strat_rd;
      pout_q <= inside_q & prev_rd;
    end else if (cmd_i.load_gen) begin
      kind_q <= 1'b1;
      sout_q <= 1'b0;
      pout_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_read || cmd_i.load_gen) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_valid_o         = out_valid_q;
  assign result_kind_o       = kind_q;
  assign strategy_out_o      = sout_q;
  assign previous_strategy_o = pout_q;

  assign stat_o.pos_last = col_last && row_last;
  assign stat_o.out_free = !out_valid_q || rsp_ready_i;
  assign stat_o.out_full = out_valid_q;

endmodule

### hw/rtl/spatial_dilemma_grid_step.sv
// ----------------------------------------------------------------------------
// spatial_dilemma_grid_step
// Grid of cooperate/defect cells stepped one generation at a time.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    opcode, row, column, strategy_in
//   rsp_o    out  valid/ready    result_kind, strategy_out, previous_strategy
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// A write is stored when the request is taken; a read goes through the READ
// state before the result register is loaded. In a generation one strategy/score
// RAM read port steps through self and eight neighbours in both the scoring and
// choosing sweeps; the commit sweep copies each cell's pending strategy back.
// A request is taken only while idle and the result register is free or
// being drained. No clearing pass after reset.
// ----------------------------------------------------------------------------
module spatial_dilemma_grid_step #(
  parameter int MaxSide = sdg_pkg::MAX_SIDE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sdg_req_if.sink                        req_i,
  sdg_rsp_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [sdg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sdg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sdg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .opcode_i    (req_i.opcode),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sdg_datapath #(.MaxSide(MaxSide)) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .opcode_i            (req_i.opcode),
    .row_i               (req_i.row),
    .column_i            (req_i.column),
    .strategy_in_i       (req_i.strategy_in),
    .rsp_valid_o         (rsp_o.valid),
    .rsp_ready_i         (rsp_o.ready),
    .result_kind_o       (rsp_o.result_kind),
    .strategy_out_o      (rsp_o.strategy_out),
    .previous_strategy_o (rsp_o.previous_strategy)
  );

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.in_take |-> !cmd.sweep)
    else $error("request taken during a sweep");

  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_read |-> $past(cmd.in_take))
    else $error("read answer loaded without a request");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_read || cmd.load_gen) |-> !stat.out_full)
    else $error("result register overwritten");

  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.out_full && !rsp_o.ready) |-> !cmd.in_take)
    else $error("request taken while result blocked");
`endif

endmodule
